// ===== rtl/fsda_pkg.sv =====
package fsda_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEGATE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic negate_step;
    logic convert_step;
    logic digit_step;
  } step_ctrl_t;

  localparam logic [5:0] SCALE_RESET = 6'd2;
  localparam logic [5:0] SCALE_MAX   = 6'd37;
  localparam int         MIN_DIGITS  = 38;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

endpackage

// ===== rtl/fixed_scale_decimal_to_ascii.sv =====
// channel  | signals                               | contents
// ---------+---------------------------------------+------------------------------------
// s_axis   | s_axis_tvalid/tready/tdata[127:0]     | value_high [63:0], value_low [127:64]
// m_axis   | m_axis_tvalid/tready/tdata[7:0]/tlast | character [7:0]; tlast = last
// cfg      | cfg_valid/ready/data[5:0]             | scale
//
// One value in flight: a load, serial negation over VALUE_BITS bits, then
// shift-and-add-3 conversion over VALUE_BITS bits, then the characters, top digit
// first, each skipped leading zero also taking a step (the digit register holds DIGITS digits).
// rst is synchronous; scale returns to 2. A stalled m_axis holds the character
// register and the digit walk; s_axis is ready only between values.
module fixed_scale_decimal_to_ascii #(
  parameter int VALUE_BITS = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // value_high [63:0], value_low [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // character [7:0]
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data
);

  localparam int DIGITS_RAW = (VALUE_BITS * 30103) / 100000 + 2;
  localparam int DIGITS     = DIGITS_RAW > fsda_pkg::MIN_DIGITS ?
                              DIGITS_RAW : fsda_pkg::MIN_DIGITS;
  localparam int PW         = $clog2(DIGITS);
  localparam int CW         = $clog2(VALUE_BITS);
  localparam int CMPW       = PW + 7;
  localparam logic [CW-1:0] LAST_BIT  = CW'(VALUE_BITS - 1);
  localparam logic [PW-1:0] TOP_DIGIT = PW'(DIGITS - 1);

  fsda_pkg::state_t     state, state_next;
  fsda_pkg::step_ctrl_t ctrl;

  logic [5:0]      scale;
  logic [5:0]      sc;
  logic [CW-1:0]   count;
  logic [PW-1:0]   pos;
  logic            minus_pending;
  logic            started;
  logic            point_done;
  logic            neg;
  logic            msb;
  logic [3:0]      top_digit;
  logic            in_accept;
  logic            can_emit;
  logic            emit_valid;
  logic [7:0]      emit_char;
  logic            emit_last;
  logic            take_minus;
  logic            take_point;
  logic            take_digit;
  logic [127:0]    joined;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] sc_ext;

  assign joined    = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign can_emit  = !m_axis_tvalid || m_axis_tready;
  assign pos_ext   = CMPW'(pos);
  assign sc_ext    = CMPW'(sc);
  assign cfg_ready = 1'b1;

  assign s_axis_tready = (state == fsda_pkg::ST_IDLE);

  fsda_magnitude #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mag (
    .clk  (clk),
    .ctrl (ctrl),
    .value(joined[VALUE_BITS-1:0]),
    .neg  (neg),
    .msb  (msb)
  );

  fsda_bcd #(
    .DIGITS(DIGITS)
  ) u_bcd (
    .clk      (clk),
    .ctrl     (ctrl),
    .bit_in   (msb),
    .top_digit(top_digit)
  );

  always_comb begin
    state_next = state;
    case (state)
      fsda_pkg::ST_IDLE: begin
        if (in_accept) state_next = fsda_pkg::ST_NEGATE;
      end
      fsda_pkg::ST_NEGATE: begin
        if (count == LAST_BIT) state_next = fsda_pkg::ST_CONVERT;
      end
      fsda_pkg::ST_CONVERT: begin
        if (count == LAST_BIT) state_next = fsda_pkg::ST_EMIT;
      end
      fsda_pkg::ST_EMIT: begin
        if (take_digit && pos == '0) state_next = fsda_pkg::ST_IDLE;
      end
      default: state_next = fsda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    emit_valid = 1'b0;
    emit_char  = fsda_pkg::CHAR_ZERO;
    emit_last  = 1'b0;
    take_minus = 1'b0;
    take_point = 1'b0;
    take_digit = 1'b0;
    case (state)
      fsda_pkg::ST_IDLE: begin
        ctrl.load = in_accept;
      end
      fsda_pkg::ST_NEGATE: begin
        ctrl.negate_step = 1'b1;
      end
      fsda_pkg::ST_CONVERT: begin
        ctrl.convert_step = 1'b1;
      end
      fsda_pkg::ST_EMIT: begin
        if (can_emit) begin
          if (minus_pending) begin
            emit_valid = 1'b1;
            emit_char  = fsda_pkg::CHAR_MINUS;
            take_minus = 1'b1;
          end else if (!started && top_digit == 4'd0 && pos_ext > sc_ext) begin
            // drop a leading zero
            ctrl.digit_step = 1'b1;
          end else if (pos_ext + CMPW'(1) == sc_ext && !point_done) begin
            emit_valid = 1'b1;
            emit_char  = fsda_pkg::CHAR_POINT;
            take_point = 1'b1;
          end else begin
            emit_valid      = 1'b1;
            emit_char       = fsda_pkg::CHAR_ZERO + {4'd0, top_digit};
            emit_last       = (pos == '0);
            take_digit      = 1'b1;
            ctrl.digit_step = 1'b1;
          end
        end
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fsda_pkg::ST_IDLE;
      scale         <= fsda_pkg::SCALE_RESET;
      count         <= '0;
      pos           <= TOP_DIGIT;
      minus_pending <= 1'b0;
      started       <= 1'b0;
      point_done    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        scale <= cfg_data;
      end
      if (ctrl.load) begin
        count         <= '0;
        pos           <= TOP_DIGIT;
        minus_pending <= 1'b0;
        started       <= 1'b0;
        point_done    <= 1'b0;
      end else if (ctrl.negate_step || ctrl.convert_step) begin
        count <= (count == LAST_BIT) ? '0 : count + CW'(1);
      end
      if (state == fsda_pkg::ST_NEGATE && count == LAST_BIT) begin
        minus_pending <= neg;
      end
      if (take_minus) begin
        minus_pending <= 1'b0;
      end
      if (take_point) begin
        point_done <= 1'b1;
      end
      if (ctrl.digit_step) begin
        pos        <= pos - PW'(1);
        point_done <= 1'b0;
      end
      if (take_digit) begin
        started <= 1'b1;
      end
      if (emit_valid) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sc <= (scale > fsda_pkg::SCALE_MAX) ? fsda_pkg::SCALE_MAX : scale;
    end
    if (emit_valid) begin
      m_axis_tdata <= emit_char;
      m_axis_tlast <= emit_last;
    end
  end

endmodule

// ===== rtl/fsda_magnitude.sv =====
module fsda_magnitude #(
  parameter int VALUE_BITS = 128
) (
  input  logic                       clk,
  input  fsda_pkg::step_ctrl_t       ctrl,
  input  logic [VALUE_BITS-1:0]      value,
  output logic                       neg,
  output logic                       msb
);

  logic [VALUE_BITS-1:0] shreg;
  logic                  seen_one;
  logic                  neg_bit;

  assign neg_bit = neg && seen_one ? ~shreg[0] : shreg[0];
  assign msb     = shreg[VALUE_BITS-1];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg    <= value;
      neg      <= value[VALUE_BITS-1];
      seen_one <= 1'b0;
    end else if (ctrl.negate_step) begin
      // two's complement LSB first: copy up to the first one, invert above it
      shreg    <= {neg_bit, shreg[VALUE_BITS-1:1]};
      seen_one <= seen_one | shreg[0];
    end else if (ctrl.convert_step) begin
      shreg    <= {shreg[VALUE_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/fsda_bcd.sv =====
module fsda_bcd #(
  parameter int DIGITS = 40
) (
  input  logic                 clk,
  input  fsda_pkg::step_ctrl_t ctrl,
  input  logic                 bit_in,
  output logic [3:0]           top_digit
);

  logic [4*DIGITS-1:0] bcd;
  logic [4*DIGITS-1:0] adjusted;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adjusted[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adjusted[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd[4*DIGITS-1 -: 4];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bcd <= '0;
    end else if (ctrl.convert_step) begin
      bcd <= {adjusted[4*DIGITS-2:0], bit_in};
    end else if (ctrl.digit_step) begin
      bcd <= {bcd[4*DIGITS-5:0], 4'd0};
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // value_high [63:0], value_low [127:64]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;   // character [7:0]
  logic         m_axis_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [5:0]   cfg_data;

  text_char_t   pending_chars[$];
  logic [5:0]   scale_setting = fsda_pkg::SCALE_RESET;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  logic         src_gaps = 1'b0;
  logic         sink_stalls = 1'b0;

  fixed_scale_decimal_to_ascii dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_pause();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
  endfunction

  function automatic logic [127:0] pow10(int k);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < k; i++) p = p * 128'd10;
    return p;
  endfunction

  function automatic void add_char(logic [7:0] ch, logic last);
    text_char_t c;
    c.character = ch;
    c.last      = last;
    pending_chars.insert(pending_chars.size(), c);
  endfunction

  // expected text of one value at the current scale
  function automatic void render_decimal(logic [127:0] value);
    logic         negative;
    logic [127:0] mag;
    logic [3:0]   digits[40];
    int           nd;
    int           total;
    int           sc;
    sc = (scale_setting > fsda_pkg::SCALE_MAX) ? int'(fsda_pkg::SCALE_MAX)
                                                : int'(scale_setting);
    negative = value[127];
    mag = negative ? (~value + 128'd1) : value;
    nd = 0;
    while (mag != 128'd0) begin
      digits[nd] = 4'(mag % 128'd10);
      mag = mag / 128'd10;
      nd++;
    end
    total = (nd < sc + 1) ? sc + 1 : nd;
    for (int p = nd; p < total; p++) digits[p] = 4'd0;
    if (negative) add_char(fsda_pkg::CHAR_MINUS, 1'b0);
    for (int p = total - 1; p >= 0; p--) begin
      if (p + 1 == sc) add_char(fsda_pkg::CHAR_POINT, 1'b0);
      add_char(fsda_pkg::CHAR_ZERO + 8'(digits[p]), p == 0);
    end
  endfunction

  function automatic logic [127:0] random_value();
    logic [127:0] v;
    int           kind;
    v = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 5);
    case (kind)
      0: ;
      1: v = 128'($urandom_range(0, 999));
      2: v = {{64{v[63]}}, v[63:0]};
      3: v = pow10($urandom_range(0, 38)) + 128'($urandom_range(0, 2)) - 128'd1;
      4: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, 127'd0};
          1: v = {1'b0, {127{1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = v >> $urandom_range(0, 127);
    endcase
    if (kind != 4 && $urandom_range(0, 1) == 1) v = ~v + 128'd1;
    return v;
  endfunction

  // valid is left high after a beat; the next call drops it for a gap or puts the next value on it, the drain drops it
  task automatic send_value(logic [127:0] value);
    int gap;
    gap = src_gaps ? pick_pause() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value[63:0], value[127:64]};
    do @(posedge clk); while (!s_axis_tready);
    render_decimal(value);
  endtask

  task automatic drain_text();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(logic [5:0] value);
    drain_text();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_setting = value;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_pause();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : char_checker
    text_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual char %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.character) begin
          mismatches++;
          $display("%0t: character expected %h actual %h",
                   $time, want.character, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) begin
          mismatches++;
          $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  task automatic test_reset_scale();
    sink_stalls = 1'b1;
    send_value(128'd0);
    send_value(128'd5);
    send_value(128'(-5));
    send_value(128'd12345);
    send_value(128'(-12345));
    send_value(128'd100);
    send_value(128'(-1));
    send_value({1'b1, 127'd0});
    send_value({1'b0, {127{1'b1}}});
  endtask

  task automatic test_scale_extremes();
    write_scale(6'd0);
    send_value(128'd0);
    send_value(128'(-7));
    send_value({1'b1, 127'd0});
    send_value({1'b0, {127{1'b1}}});
    write_scale(fsda_pkg::SCALE_MAX);
    send_value(128'd0);
    send_value(128'(-1));
    send_value({1'b1, 127'd0});
    send_value(pow10(37));
    write_scale(6'd63);
    send_value(128'd12345);
    send_value(128'(-3));
    write_scale(6'd38);
    send_value(128'd1);
  endtask

  task automatic test_random_phases();
    logic [5:0] next_scale;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: next_scale = 6'($urandom_range(0, 63));
        1: next_scale = 6'd0;
        2: next_scale = fsda_pkg::SCALE_MAX;
        default: next_scale = 6'($urandom_range(38, 63));
      endcase
      write_scale(next_scale);
      src_gaps = (ph % 3 != 0);
      sink_stalls = (ph % 3 != 0);
      repeat (27) send_value(random_value());
    end
  endtask

  task automatic test_drain_between_values();
    write_scale(6'($urandom_range(1, 20)));
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (8) begin
      send_value(random_value());
      drain_text();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_scale();
    test_scale_extremes();
    test_random_phases();
    test_drain_between_values();
    drain_text();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
